/* sv/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam cnt_t       CNT_FULL   = CNT_W'(DEPTH);
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_NEW,
    S_DEQ_RD,
    S_RESULT
  } state_t;

  typedef struct packed {
    word_t data;
    word_t prio;
  } entry_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    logic wr_sel_new;
  } mem_ctl_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    deq_ok;
  } res_t;

  // ring buffer address of logical slot off behind the head
  function automatic idx_t phys_addr(idx_t base, idx_t off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/sorted_priority_queue.sv */
// Bounded priority queue of DEPTH entries (16) kept sorted, highest signed priority at the
// head, equal priorities in arrival order. s_tuser selects enqueue (0) or dequeue (1); every
// word in gives one result word out with status, removed head and occupancy. Entries live in
// a single-port-per-direction ring buffer memory; one comparator and a small sequencer walk
// it from the tail. A dequeue reads the head (S_DEQ_RD), then goes to S_RESULT. An enqueue
// reads a stored entry (S_ENQ_RD) and compares it with the new word once the registered
// read is back (S_ENQ_CMP): a lower entry moves back a slot and the walk repeats; otherwise
// the new word goes in behind it. After all stored entries have moved, S_ENQ_NEW writes the
// new word. A dropped enqueue or an empty dequeue goes straight to S_RESULT. Input is taken
// only between operations; a finished result waits in the output register.
`default_nettype none

module sorted_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // data_in[31:0], priority_in[63:32]
  input  wire logic [0:0]  s_tuser,   // cmd[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // out_data[31:0], out_priority[63:32], occupancy[68:64]
  output logic [1:0]       m_tuser    // status[1:0]
);
  import spq_pkg::*;

  mem_ctl_t ctl;
  res_t     res;
  cnt_t     cnt;
  word_t    item_data, item_prio;
  entry_t   rd_q;
  logic     gt;
  logic     out_free;

  word_t             out_data, out_prio;
  logic [OCC_W-1:0]  out_occ;
  status_t           out_status;

  assign out_free = !m_tvalid || m_tready;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser[0]),
    .in_data   (word_t'(s_tdata[31:0])),
    .in_prio   (word_t'(s_tdata[63:32])),
    .gt        (gt),
    .out_free  (out_free),
    .ready     (s_tready),
    .ctl       (ctl),
    .item_data (item_data),
    .item_prio (item_prio),
    .res       (res),
    .cnt       (cnt)
  );

  spq_store u_store (
    .clk       (clk),
    .ctl       (ctl),
    .item_data (item_data),
    .item_prio (item_prio),
    .rd_q      (rd_q),
    .gt        (gt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_status <= res.status;
      out_data   <= res.deq_ok ? rd_q.data : '0;
      out_prio   <= res.deq_ok ? rd_q.prio : '0;
      out_occ    <= OCC_W'(cnt);
    end
  end

  assign m_tdata = {3'b000, out_occ, out_prio, out_data};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

/* sv/spq_store.sv */
`default_nettype none

module spq_store (
  input  wire logic              clk,
  input  wire spq_pkg::mem_ctl_t ctl,
  input  wire spq_pkg::word_t    item_data,
  input  wire spq_pkg::word_t    item_prio,
  output spq_pkg::entry_t        rd_q,
  output logic                   gt
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t wr_entry;

  assign wr_entry = ctl.wr_sel_new ? entry_t'{data: item_data, prio: item_prio} : rd_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[ctl.wr_addr] <= wr_entry;
    if (ctl.rd_en) rd_q <= mem[ctl.rd_addr];
  end

  // the one comparator: new priority strictly above the entry just read
  assign gt = item_prio > rd_q.prio;

endmodule

`default_nettype wire

/* sv/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  input  wire spq_pkg::word_t    in_data,
  input  wire spq_pkg::word_t    in_prio,
  input  wire logic              gt,
  input  wire logic              out_free,
  output logic                   ready,
  output spq_pkg::mem_ctl_t      ctl,
  output spq_pkg::word_t         item_data,
  output spq_pkg::word_t         item_prio,
  output spq_pkg::res_t          res,
  output spq_pkg::cnt_t          cnt
);
  import spq_pkg::*;

  state_t  state, state_next;
  idx_t    hd;
  idx_t    k;
  status_t res_status;
  logic    res_deq;
  logic    accept;

  assign ready  = (state == S_IDLE);
  assign accept = in_valid && ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ENQ) begin
            if (cnt == CNT_FULL)   state_next = S_RESULT;
            else if (cnt == '0)    state_next = S_ENQ_NEW;
            else                   state_next = S_ENQ_RD;
          end else begin
            if (cnt == '0)         state_next = S_RESULT;
            else                   state_next = S_DEQ_RD;
          end
        end
      end
      S_ENQ_RD:  state_next = S_ENQ_CMP;
      S_ENQ_CMP: begin
        if (gt) state_next = (k == IDX_W'(1)) ? S_ENQ_NEW : S_ENQ_RD;
        else    state_next = S_RESULT;
      end
      S_ENQ_NEW: state_next = S_RESULT;
      S_DEQ_RD:  state_next = S_RESULT;
      S_RESULT:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    res = '{load: 1'b0, status: res_status, deq_ok: res_deq};
    unique case (state)
      S_ENQ_RD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = phys_addr(hd, k - IDX_W'(1));
      end
      S_ENQ_CMP: begin
        // shift the lower entry back one slot, or drop the new word in here
        ctl.wr_en      = 1'b1;
        ctl.wr_addr    = phys_addr(hd, k);
        ctl.wr_sel_new = !gt;
      end
      S_ENQ_NEW: begin
        ctl.wr_en      = 1'b1;
        ctl.wr_addr    = phys_addr(hd, k);
        ctl.wr_sel_new = 1'b1;
      end
      S_DEQ_RD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = hd;
      end
      S_RESULT: res.load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      hd    <= '0;
    end else begin
      state <= state_next;
      if ((state == S_ENQ_CMP && !gt) || state == S_ENQ_NEW) cnt <= cnt + CNT_W'(1);
      if (state == S_DEQ_RD) begin
        cnt <= cnt - CNT_W'(1);
        hd  <= phys_addr(hd, IDX_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_data <= in_data;
      item_prio <= in_prio;
      k         <= IDX_W'(cnt);
      res_deq   <= (in_cmd == CMD_DEQ) && (cnt != '0);
      if (in_cmd == CMD_ENQ && cnt == CNT_FULL) res_status <= ST_FULL;
      else if (in_cmd == CMD_DEQ && cnt == '0)  res_status <= ST_EMPTY;
      else                                      res_status <= ST_OK;
    end else if (state == S_ENQ_CMP && gt) begin
      k <= k - IDX_W'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_FULL)
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res.load && res.status == ST_FULL) |-> cnt == CNT_FULL)
    else $error("full status with free slots");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (res.load && res.status == ST_EMPTY) |-> cnt == '0)
    else $error("empty status with stored entries");

  a_no_mem_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESULT) |-> !(ctl.wr_en || ctl.rd_en))
    else $error("memory access outside an operation");

endmodule

`default_nettype wire

/* tb/sorted_priority_queue_tb.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RUN_ITEMS   = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    status_t          status;
    word_t            data;
    word_t            prio;
    logic [OCC_W-1:0] occ;
  } reply_t;

  // keeps its own sorted copy of the queue and the replies still owed by the block
  class spq_scoreboard;
    word_t  slot_data[$];
    word_t  slot_prio[$];
    reply_t replies_due[$];
    int     fails = 0;

    function void note_word(logic cmd, word_t din, word_t pin);
      reply_t r;
      int     pos;
      r.status = ST_OK;
      r.data = '0;
      r.prio = '0;
      if (cmd == CMD_ENQ) begin
        if (slot_prio.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < slot_prio.size() && !(pin > slot_prio[pos])) pos++;
          slot_data.insert(pos, din);
          slot_prio.insert(pos, pin);
        end
      end else begin
        if (slot_prio.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = slot_data.pop_front();
          r.prio = slot_prio.pop_front();
        end
      end
      r.occ = OCC_W'(slot_prio.size());
      replies_due.push_back(r);
    endfunction

    function void check_word(logic [71:0] tdata, logic [1:0] tuser);
      reply_t r;
      if (replies_due.size() == 0) begin
        $error("result word with no pending operation: tdata=%h tuser=%h", tdata, tuser);
        fails++;
        return;
      end
      r = replies_due.pop_front();
      if (tuser !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, tuser);
        fails++;
      end
      if (tdata[31:0] !== r.data) begin
        $error("out_data: expected %h, got %h", r.data, tdata[31:0]);
        fails++;
      end
      if (tdata[63:32] !== r.prio) begin
        $error("out_priority: expected %h, got %h", r.prio, tdata[63:32]);
        fails++;
      end
      if (tdata[68:64] !== r.occ) begin
        $error("occupancy: expected %0d, got %0d", r.occ, tdata[68:64]);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  spq_scoreboard sb = new;
  int send_mode = 0;
  int recv_mode = 0;
  int cycles = 0;

  sorted_priority_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mode 0 never idles, mode 1 idles freely, others idle now and then
  function automatic int idle_cycles(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // mix of ties around zero, the extremes and full-range values
  function automatic word_t pick_prio();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom_range(0, 6)) - 3;
      4: return 32'h7fff_ffff;
      5: return 32'h8000_0000;
      6: return ($urandom_range(0, 1) == 1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_data();
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge; valid stays high when the next word follows at once
  task automatic push_word(logic cmd, word_t din, word_t pin);
    int gap;
    gap = idle_cycles(send_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pin, din};
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(cmd, din, pin);
    @(negedge clk);
  endtask

  task automatic pop_word();
    push_word(CMD_DEQ, $urandom, $urandom);
  endtask

  // result side
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_cycles(recv_mode);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_word(m_tdata, m_tuser);
      @(negedge clk);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_priority_queue_tb NOT OK");
    $finish;
  end

  initial begin
    int    sent;
    int    seg_len;
    int    enq_pct;
    word_t pin;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, extremes, ties at zero and at the top priority
    pop_word();
    push_word(CMD_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
    push_word(CMD_ENQ, 32'h8000_0000, 32'h8000_0000);
    push_word(CMD_ENQ, 32'h0000_0001, 32'h0);
    push_word(CMD_ENQ, 32'hffff_ffff, 32'hffff_ffff);
    push_word(CMD_ENQ, 32'h0000_0002, 32'h0);
    push_word(CMD_ENQ, 32'h0000_0003, 32'h0);
    push_word(CMD_ENQ, 32'h0000_0000, 32'h7fff_ffff);
    repeat (7) pop_word();
    pop_word();

    // random: segments lean toward filling, draining or hovering
    sent = 0;
    while (sent < RUN_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 85;
      endcase
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      repeat (seg_len) begin
        if ($urandom_range(1, 100) <= enq_pct) begin
          pin = pick_prio();
          push_word(CMD_ENQ, pick_data(), pin);
        end else begin
          pop_word();
        end
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fails == 0) begin
      $display("sorted_priority_queue_tb OK");
    end else begin
      $display("sorted_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue.f */
sv/spq_pkg.sv
sv/spq_store.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
